// ===== rtl/obp_pkg.sv =====
// obp_pkg: shared types and constants for the occupancy block pooling design
// no dependencies; used by obp_cursor and occupancy_block_pooling

package obp_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd2;

    localparam int GRID_REG_W  = 13;
    localparam int BLOCK_REG_W = 5;

    // register reset values
    localparam int GRID_WIDTH_RST  = 4096;
    localparam int GRID_HEIGHT_RST = 4096;
    localparam int BLOCK_SIZE_RST  = 10;

    // payload widths
    localparam int CELL_W  = 8;
    localparam int COORD_W = 12;

    // frame generation tag kept with every column flag
    localparam int EPOCH_W = 8;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic               flag;
    } flag_entry_t;

    // edge status of the cell being processed
    typedef struct packed {
        logic col_end;
        logic row_end;
        logic blk_col_end;
        logic blk_row_end;
    } cursor_flags_t;

endpackage

// ===== rtl/obp_ram.sv =====
// obp_ram: generic single write port, single read port ram with registered read
// no dependencies

module obp_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/obp_cursor.sv =====
// obp_cursor: raster position of the next cell, its place inside its block
// and the block coordinates; depends on obp_pkg

module obp_cursor #(
    parameter int WCW = 12,
    parameter int HCW = 12,
    parameter int BW  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  frame_start,
    input  logic [WCW-1:0]        wm1,
    input  logic [HCW-1:0]        hm1,
    input  logic [BW-1:0]         bsm1,
    output obp_pkg::cursor_flags_t flags,
    output logic [HCW-1:0]        blk_row,
    output logic [WCW-1:0]        blk_col,
    output logic [WCW-1:0]        rd_col
);

    logic [WCW-1:0] col_reg, col_next, col_cur;
    logic [HCW-1:0] row_reg, row_next, row_cur;
    logic [BW-1:0]  cib_reg, cib_next, cib_cur;
    logic [BW-1:0]  rib_reg, rib_next, rib_cur;
    logic [WCW-1:0] bcol_reg, bcol_next, bcol_cur;
    logic [HCW-1:0] brow_reg, brow_next, brow_cur;

    always_comb
    begin
        // a frame start restarts the position before the transaction is used
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        cib_cur  = frame_start ? '0 : cib_reg;
        rib_cur  = frame_start ? '0 : rib_reg;
        bcol_cur = frame_start ? '0 : bcol_reg;
        brow_cur = frame_start ? '0 : brow_reg;

        flags.col_end     = col_cur >= wm1;
        flags.row_end     = row_cur >= hm1;
        flags.blk_col_end = flags.col_end || (cib_cur >= bsm1);
        flags.blk_row_end = flags.row_end || (rib_cur >= bsm1);

        col_next  = col_cur;
        row_next  = row_cur;
        cib_next  = cib_cur;
        rib_next  = rib_cur;
        bcol_next = bcol_cur;
        brow_next = brow_cur;

        if (flags.col_end)
        begin
            col_next  = '0;
            cib_next  = '0;
            bcol_next = '0;
            if (flags.row_end)
            begin
                row_next  = '0;
                rib_next  = '0;
                brow_next = '0;
            end
            else
            begin
                row_next = row_cur + HCW'(1);
                if (flags.blk_row_end)
                begin
                    rib_next  = '0;
                    brow_next = brow_cur + HCW'(1);
                end
                else
                begin
                    rib_next = rib_cur + BW'(1);
                end
            end
        end
        else
        begin
            col_next = col_cur + WCW'(1);
            if (flags.blk_col_end)
            begin
                cib_next  = '0;
                bcol_next = bcol_cur + WCW'(1);
            end
            else
            begin
                cib_next = cib_cur + BW'(1);
            end
        end
    end

    assign blk_row = brow_cur;
    assign blk_col = bcol_cur;
    // flag store read address: the block column of the next processed cell
    assign rd_col  = advance ? bcol_next : bcol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cib_reg  <= '0;
            rib_reg  <= '0;
            bcol_reg <= '0;
            brow_reg <= '0;
        end
        else if (advance)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cib_reg  <= cib_next;
            rib_reg  <= rib_next;
            bcol_reg <= bcol_next;
            brow_reg <= brow_next;
        end
    end

endmodule

// ===== rtl/occupancy_block_pooling.sv =====
// an accepted cell is held in the input stage register, then its block result in
// the output register. throughput: one cell per cycle unless a blocked result or a
// sweep stalls it, limited by the single flag store write port. reset: control
// clears at once, then the whole flag store is swept with in_stall high; every
// 256th frame start sweeps it again. configuration writes are taken at any time.
// occupancy_block_pooling: top level; depends on obp_pkg, obp_ram, obp_cursor

module occupancy_block_pooling #(
    parameter int MAX_GRID_WIDTH  = 4096,
    parameter int MAX_GRID_HEIGHT = 4096,
    parameter int MAX_BLOCK       = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_write,
    input  logic [obp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [obp_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [obp_pkg::CELL_W-1:0] cell_value,
    input  logic                             frame_start,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             block_occupied,
    output logic [obp_pkg::COORD_W-1:0]      block_row,
    output logic [obp_pkg::COORD_W-1:0]      block_col,
    output logic                             last_block
);

    localparam int WCW = (MAX_GRID_WIDTH > 1) ? $clog2(MAX_GRID_WIDTH) : 1;
    localparam int HCW = (MAX_GRID_HEIGHT > 1) ? $clog2(MAX_GRID_HEIGHT) : 1;
    localparam int BW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    localparam int WM1_RST = ((obp_pkg::GRID_WIDTH_RST > MAX_GRID_WIDTH) ?
                              MAX_GRID_WIDTH : obp_pkg::GRID_WIDTH_RST) - 1;
    localparam int HM1_RST = ((obp_pkg::GRID_HEIGHT_RST > MAX_GRID_HEIGHT) ?
                              MAX_GRID_HEIGHT : obp_pkg::GRID_HEIGHT_RST) - 1;
    localparam int BSM1_RST = ((obp_pkg::BLOCK_SIZE_RST > MAX_BLOCK) ?
                               MAX_BLOCK : obp_pkg::BLOCK_SIZE_RST) - 1;
    localparam int ENTRY_W = $bits(obp_pkg::flag_entry_t);
    localparam logic [WCW-1:0] LAST_ADDR = WCW'(MAX_GRID_WIDTH - 1);

    // configuration, kept as size minus one after clamping
    logic [WCW-1:0] wm1_reg, wm1_next;
    logic [HCW-1:0] hm1_reg, hm1_next;
    logic [BW-1:0]  bsm1_reg, bsm1_next;

    logic [obp_pkg::GRID_REG_W-1:0]  grid_val;
    logic [obp_pkg::BLOCK_REG_W-1:0] blk_val;

    // input stage
    logic s1_valid_reg, s1_valid_next;
    logic s1_occ_reg;
    logic s1_fs_reg;
    logic accept;
    logic advance;
    logic out_free;

    // flag store
    logic                         clearing_reg, clearing_next;
    logic [WCW-1:0]               clr_addr_reg, clr_addr_next;
    logic [obp_pkg::EPOCH_W-1:0]  epoch_reg, epoch_next;
    logic                         ram_we;
    logic [WCW-1:0]               ram_waddr;
    obp_pkg::flag_entry_t         ram_wdata;
    obp_pkg::flag_entry_t         ram_rdata;
    logic                         byp_valid_reg;
    logic [WCW-1:0]               byp_addr_reg;
    obp_pkg::flag_entry_t         byp_data_reg;
    obp_pkg::flag_entry_t         entry_rd;
    logic                         flag_old;
    logic                         flag_new;
    logic                         has_result;

    obp_pkg::cursor_flags_t cur_flags;
    logic [HCW-1:0]         cur_brow;
    logic [WCW-1:0]         cur_bcol;
    logic [WCW-1:0]         rd_col;

    // output register
    logic                        out_valid_reg, out_valid_next;
    logic                        occ_out_reg;
    logic [obp_pkg::COORD_W-1:0] row_out_reg;
    logic [obp_pkg::COORD_W-1:0] col_out_reg;
    logic                        last_out_reg;

    // configuration writes
    always_comb
    begin
        grid_val  = cfg_data[obp_pkg::GRID_REG_W-1:0];
        blk_val   = cfg_data[obp_pkg::BLOCK_REG_W-1:0];
        wm1_next  = wm1_reg;
        hm1_next  = hm1_reg;
        bsm1_next = bsm1_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                obp_pkg::REG_GRID_WIDTH:
                begin
                    if (grid_val == '0)
                        wm1_next = '0;
                    else if (32'(grid_val) > MAX_GRID_WIDTH)
                        wm1_next = WCW'(MAX_GRID_WIDTH - 1);
                    else
                        wm1_next = WCW'(grid_val - 1'b1);
                end
                obp_pkg::REG_GRID_HEIGHT:
                begin
                    if (grid_val == '0)
                        hm1_next = '0;
                    else if (32'(grid_val) > MAX_GRID_HEIGHT)
                        hm1_next = HCW'(MAX_GRID_HEIGHT - 1);
                    else
                        hm1_next = HCW'(grid_val - 1'b1);
                end
                obp_pkg::REG_BLOCK_SIZE:
                begin
                    if (blk_val == '0)
                        bsm1_next = '0;
                    else if (32'(blk_val) > MAX_BLOCK)
                        bsm1_next = BW'(MAX_BLOCK - 1);
                    else
                        bsm1_next = BW'(blk_val - 1'b1);
                end
                default:
                begin
                    wm1_next = wm1_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wm1_reg  <= WCW'(WM1_RST);
            hm1_reg  <= HCW'(HM1_RST);
            bsm1_reg <= BW'(BSM1_RST);
        end
        else
        begin
            wm1_reg  <= wm1_next;
            hm1_reg  <= hm1_next;
            bsm1_reg <= bsm1_next;
        end
    end

    // handshake
    assign out_free      = !out_valid_reg || !out_stall;
    assign advance       = s1_valid_reg && out_free && !clearing_reg;
    assign in_stall      = clearing_reg || (s1_valid_reg && !advance);
    assign accept        = in_valid && !in_stall;
    assign s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_occ_reg <= cell_value != '0;
            s1_fs_reg  <= frame_start;
        end
    end

    obp_cursor #(
        .WCW (WCW),
        .HCW (HCW),
        .BW  (BW)
    ) u_cursor (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .frame_start (s1_fs_reg),
        .wm1         (wm1_reg),
        .hm1         (hm1_reg),
        .bsm1        (bsm1_reg),
        .flags       (cur_flags),
        .blk_row     (cur_brow),
        .blk_col     (cur_bcol),
        .rd_col      (rd_col)
    );

    // column flags: an entry counts only when its tag matches the current frame
    // generation; when the generation wraps the store is swept back to zero
    always_comb
    begin
        entry_rd = (byp_valid_reg && (byp_addr_reg == cur_bcol)) ? byp_data_reg : ram_rdata;
        flag_old = !s1_fs_reg && (entry_rd.tag == epoch_reg) && entry_rd.flag;
        flag_new = flag_old || s1_occ_reg;
        has_result = cur_flags.blk_col_end && cur_flags.blk_row_end;

        epoch_next    = epoch_reg;
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;

        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + WCW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end
        else if (advance && s1_fs_reg)
        begin
            epoch_next = epoch_reg + obp_pkg::EPOCH_W'(1);
            // column zero is written by this transaction, sweep the rest
            if ((epoch_reg == '1) && (MAX_GRID_WIDTH > 1))
            begin
                clearing_next = 1'b1;
                clr_addr_next = WCW'(1);
            end
        end

        ram_we    = clearing_reg || advance;
        ram_waddr = clearing_reg ? clr_addr_reg : cur_bcol;
        if (clearing_reg)
        begin
            ram_wdata = '0;
        end
        else
        begin
            ram_wdata.tag  = epoch_next;
            ram_wdata.flag = flag_new && !has_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            epoch_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            epoch_reg     <= epoch_next;
            byp_valid_reg <= ram_we;
        end
    end

    // last write covers the read that happened at the same edge
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            byp_addr_reg <= ram_waddr;
            byp_data_reg <= ram_wdata;
        end
    end

    obp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_GRID_WIDTH)
    ) u_flag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_col),
        .rdata (ram_rdata)
    );

    // result register
    assign out_valid_next = advance ? has_result : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            occ_out_reg  <= flag_new;
            row_out_reg  <= obp_pkg::COORD_W'(cur_brow);
            col_out_reg  <= obp_pkg::COORD_W'(cur_bcol);
            last_out_reg <= cur_flags.col_end && cur_flags.row_end;
        end
    end

    assign out_valid      = out_valid_reg;
    assign block_occupied = occ_out_reg;
    assign block_row      = row_out_reg;
    assign block_col      = col_out_reg;
    assign last_block     = last_out_reg;

`ifndef ASSERT_OFF
    // the input stage waits only on a blocked result register or a sweep
    a_s1_wait: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance && !clearing_reg |-> out_valid_reg && out_stall)
        else $error("input stage held without a blocked result");

    // a sweep after reset release starts only on a generation wrap
    a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg && !$past(clearing_reg) |->
            $past(advance && s1_fs_reg && (epoch_reg == '1)))
        else $error("flag store sweep started without a generation wrap");

    // a nonzero cell always marks the block it closes
    a_occ_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_result && s1_occ_reg |=> out_valid && block_occupied)
        else $error("occupied cell lost from its block result");

    // no transaction is taken while the flag store is swept
    a_sweep_stall: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |=> !$past(accept) && !$past(advance))
        else $error("transaction taken during flag store sweep");
`endif

endmodule

// ===== test/occupancy_block_pooling_test.sv =====
// occupancy_block_pooling_test: self-checking testbench for the block pooling top level
// drives cell transactions under random idling and compares every block result with
// its own model of the pooling; depends on obp_pkg and the occupancy_block_pooling rtl

module occupancy_block_pooling_test;

    localparam int MAX_W          = 4096;
    localparam int MAX_H          = 4096;
    localparam int MAX_BS         = 16;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 500;
    localparam int EDGE_RUN       = 120;

    typedef struct packed {
        logic                        occupied;
        logic [obp_pkg::COORD_W-1:0] row;
        logic [obp_pkg::COORD_W-1:0] col;
        logic                        last;
    } block_result_t;

    logic                              clk;
    logic                              rst_n;
    logic                              cfg_write;
    logic [obp_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [obp_pkg::CFG_DATA_W-1:0]    cfg_data;
    logic                              in_valid;
    logic                              in_stall;
    logic signed [obp_pkg::CELL_W-1:0] cell_value;
    logic                              frame_start;
    logic                              out_valid;
    logic                              out_stall;
    logic                              block_occupied;
    logic [obp_pkg::COORD_W-1:0]       block_row;
    logic [obp_pkg::COORD_W-1:0]       block_col;
    logic                              last_block;

    // model copy of the registers and of the block's position state
    logic [obp_pkg::GRID_REG_W-1:0]  width_reg  =
        obp_pkg::GRID_REG_W'(obp_pkg::GRID_WIDTH_RST);
    logic [obp_pkg::GRID_REG_W-1:0]  height_reg =
        obp_pkg::GRID_REG_W'(obp_pkg::GRID_HEIGHT_RST);
    logic [obp_pkg::BLOCK_REG_W-1:0] bsize_reg  =
        obp_pkg::BLOCK_REG_W'(obp_pkg::BLOCK_SIZE_RST);
    bit                           flag_by_block_col [MAX_W];
    int unsigned                  pos_col, pos_row, sub_col, sub_row, blk_col, blk_row;

    block_result_t                expected_blocks [$];
    int                           error_count;
    int                           quiet_cycles;
    bit                           in_steady;
    bit                           out_steady;
    bit                           hold_request;

    occupancy_block_pooling #(
        .MAX_GRID_WIDTH  (MAX_W),
        .MAX_GRID_HEIGHT (MAX_H),
        .MAX_BLOCK       (MAX_BS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cell_value     (cell_value),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .block_occupied (block_occupied),
        .block_row      (block_row),
        .block_col      (block_col),
        .last_block     (last_block)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned limit_reg(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // pools one accepted cell and queues the block result it completes, if any
    task automatic pool_cell(input logic signed [obp_pkg::CELL_W-1:0] value, input logic fs);
        int unsigned w, h, bs, idx;
        bit col_end, row_end, bcol_end, brow_end;
        block_result_t res;
        w  = limit_reg(32'(width_reg), MAX_W);
        h  = limit_reg(32'(height_reg), MAX_H);
        bs = limit_reg(32'(bsize_reg), MAX_BS);
        if (fs)
        begin
            foreach (flag_by_block_col[i]) flag_by_block_col[i] = 1'b0;
            pos_col = 0; pos_row = 0; sub_col = 0; sub_row = 0; blk_col = 0; blk_row = 0;
        end
        idx = (blk_col >= MAX_W) ? MAX_W - 1 : blk_col;
        if (value != 0) flag_by_block_col[idx] = 1'b1;
        // a position past a shrunken edge counts as lying on that edge
        col_end  = pos_col >= w - 1;
        row_end  = pos_row >= h - 1;
        bcol_end = col_end || sub_col >= bs - 1;
        brow_end = row_end || sub_row >= bs - 1;
        if (bcol_end && brow_end)
        begin
            res.occupied = flag_by_block_col[idx];
            res.row      = obp_pkg::COORD_W'(blk_row);
            res.col      = obp_pkg::COORD_W'(blk_col);
            res.last     = col_end && row_end;
            expected_blocks.insert(expected_blocks.size(), res);
            flag_by_block_col[idx] = 1'b0;
        end
        if (col_end)
        begin
            pos_col = 0; sub_col = 0; blk_col = 0;
            if (row_end)
            begin
                pos_row = 0; sub_row = 0; blk_row = 0;
            end
            else
            begin
                pos_row++;
                if (brow_end)
                begin
                    sub_row = 0;
                    blk_row++;
                end
                else
                    sub_row++;
            end
        end
        else
        begin
            pos_col++;
            if (bcol_end)
            begin
                sub_col = 0;
                blk_col++;
            end
            else
                sub_col++;
        end
    endtask

    function automatic void report_mismatch(string field, logic [obp_pkg::COORD_W-1:0] exp_v,
                                            logic [obp_pkg::COORD_W-1:0] act_v);
        error_count++;
        $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
    endfunction

    task automatic check_block();
        block_result_t exp_r;
        if (expected_blocks.size() == 0)
        begin
            error_count++;
            $error("unexpected block result: row %0d col %0d", block_row, block_col);
            return;
        end
        exp_r = expected_blocks.pop_front();
        if (block_occupied !== exp_r.occupied)
            report_mismatch("block_occupied", obp_pkg::COORD_W'(exp_r.occupied),
                            obp_pkg::COORD_W'(block_occupied));
        if (block_row !== exp_r.row)
            report_mismatch("block_row", exp_r.row, block_row);
        if (block_col !== exp_r.col)
            report_mismatch("block_col", exp_r.col, block_col);
        if (last_block !== exp_r.last)
            report_mismatch("last_block", obp_pkg::COORD_W'(exp_r.last),
                            obp_pkg::COORD_W'(last_block));
    endtask

    // prediction first, so a result can never overtake its own cell
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) pool_cell(cell_value, frame_start);
            if (out_valid && !out_stall) check_block();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // result side stall generator
    initial
    begin : result_stall
        int r;
        int span;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (out_steady)
                out_stall <= 1'b0;
            else
            begin
                r = $urandom_range(99);
                if (r < 60)
                    out_stall <= 1'b0;
                else
                begin
                    if (r < 85)
                        span = $urandom_range(1, 3);
                    else if (r < 97)
                        span = $urandom_range(4, 12);
                    else
                        span = $urandom_range(30, 90);
                    out_stall <= 1'b1;
                    repeat (span - 1) @(posedge clk);
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (in_steady) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic signed [obp_pkg::CELL_W-1:0] random_cell(int zero_pct);
        int r;
        if ($urandom_range(99) < zero_pct) return '0;
        r = $urandom_range(3);
        if (r == 0) return obp_pkg::CELL_W'(-1);
        if (r == 1) return obp_pkg::CELL_W'($urandom_range(1, 100));
        return obp_pkg::CELL_W'($urandom());
    endfunction

    task automatic send_cell(input logic signed [obp_pkg::CELL_W-1:0] value, input logic fs);
        int gap;
        in_valid    <= 1'b1;
        cell_value  <= value;
        frame_start <= fs;
        do @(posedge clk); while (in_stall);
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender holds off until every queued block result has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_blocks.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [obp_pkg::CFG_DATA_W-1:0] w,
                                input logic [obp_pkg::CFG_DATA_W-1:0] h,
                                input logic [obp_pkg::CFG_DATA_W-1:0] b);
        logic [obp_pkg::CFG_DATA_W-1:0] data [3];
        logic [obp_pkg::CFG_IDX_W-1:0]  index [3];
        data  = '{w, h, b};
        index = '{obp_pkg::REG_GRID_WIDTH, obp_pkg::REG_GRID_HEIGHT, obp_pkg::REG_BLOCK_SIZE};
        wait_drain();
        for (int i = 0; i < 3; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= index[i];
            cfg_data  <= data[i];
            @(posedge clk);
        end
        cfg_write  <= 1'b0;
        width_reg  = w;
        height_reg = h;
        bsize_reg  = b[obp_pkg::BLOCK_REG_W-1:0];
    endtask

    // a few cells under the reset geometry: no block can end yet
    task automatic test_reset_config();
        repeat (5) send_cell(random_cell(30), 1'b0);
    endtask

    // 5x3 grid of 2x2 blocks with partial edge blocks, value extremes,
    // wrap into the next grid without frame start, then a dropped grid
    task automatic test_block_edges();
        logic signed [obp_pkg::CELL_W-1:0] grid_vals [15];
        grid_vals = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h00, 8'h00, 8'h7F, 8'h00,
                      8'h00, 8'h00, 8'hFF, 8'h00, 8'h01};
        write_config(13'd5, 13'd3, 13'd2);
        for (int i = 0; i < 15; i++) send_cell(grid_vals[i], i == 0);
        send_cell(8'h64, 1'b0);
        send_cell(8'h00, 1'b0);
        send_cell(8'h00, 1'b0);
        send_cell(8'h00, 1'b1);
    endtask

    // out of range and largest register settings
    task automatic test_register_limits();
        write_config(13'd0, 13'd0, 13'd0);
        repeat (6) send_cell(random_cell(50), 1'b0);
        in_steady = 1'b1;
        write_config(13'd4096, 13'd1, 13'd1);
        send_cell(random_cell(50), 1'b1);
        repeat (EDGE_RUN - 1) send_cell(random_cell(50), 1'b0);
        write_config(13'd1, 13'h1FFF, 13'd1);
        send_cell(random_cell(50), 1'b1);
        repeat (EDGE_RUN - 1) send_cell(random_cell(50), 1'b0);
        in_steady = 1'b0;
        write_config(13'd20, 13'd20, 13'h1FFF);
        send_cell(random_cell(80), 1'b1);
        repeat (399) send_cell(random_cell(80), 1'b0);
    endtask

    // many short grids cut off by frame start; enough of them to wrap the flag epoch
    task automatic test_frame_restarts();
        int extra;
        write_config(13'd24, 13'd1, 13'd4);
        repeat (270)
        begin
            extra = ($urandom_range(19) == 0) ? 23 : $urandom_range(0, 2);
            send_cell(random_cell(60), 1'b1);
            repeat (extra) send_cell(random_cell(60), 1'b0);
        end
    endtask

    // receiver holds off while the sender keeps offering cells, one result per cell
    task automatic test_result_backpressure();
        write_config(13'd12, 13'd8, 13'd1);
        hold_request = 1'b1;
        in_steady    = 1'b1;
        repeat (200) send_cell(random_cell(50), 1'b0);
        in_steady    = 1'b0;
    endtask

    task automatic test_random_grids();
        int sent_here, w_raw, h_raw, bs_raw, w_eff, h_eff, cells, zero_pct;
        logic fs;
        sent_here = 0;
        while (sent_here < RANDOM_ITEMS)
        begin
            w_raw  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24);
            h_raw  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            bs_raw = ($urandom_range(3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 8);
            // junk in the upper data bits must not reach the block size
            write_config(obp_pkg::CFG_DATA_W'(w_raw), obp_pkg::CFG_DATA_W'(h_raw),
                         {8'($urandom()), 5'(bs_raw)});
            in_steady  = ($urandom_range(3) == 0);
            out_steady = ($urandom_range(3) == 0);
            w_eff    = (w_raw == 0) ? 1 : w_raw;
            h_eff    = (h_raw == 0) ? 1 : h_raw;
            cells    = w_eff * h_eff * $urandom_range(1, 2);
            if ($urandom_range(2) == 0) cells += $urandom_range(1, w_eff * h_eff);
            zero_pct = $urandom_range(40, 98);
            for (int i = 0; i < cells; i++)
            begin
                fs = (i == 0) ? ($urandom_range(1) == 1) : ($urandom_range(99) < 2);
                send_cell(random_cell(zero_pct), fs);
            end
            sent_here += cells;
        end
        in_steady  = 1'b0;
        out_steady = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        cell_value  = '0;
        frame_start = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_config();
        test_block_edges();
        test_register_limits();
        test_frame_restarts();
        test_result_backpressure();
        test_random_grids();
        wait_drain();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
